FILE: hw/rtl/bts_pkg.sv
// bts_pkg: constants and types for the bilinear texture sampler
// used by bts_bank and bilinear_texture_sampler
`default_nettype none
package bts_pkg;
  localparam int ColBits = 8;
  localparam int RowBits = 8;
  localparam int ChBits = 16;
  localparam int TexBits = 3 * ChBits;
  localparam int BankAw = ColBits + RowBits - 2;
  localparam int SizeBits = 9;
  localparam logic [SizeBits-1:0] MaxCols = 9'd256;
  localparam logic [SizeBits-1:0] MaxRows = 9'd256;
  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [TexBits-1:0] texel_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bilinear_texture_sampler.sv
// bilinear_texture_sampler: texel store in four banks split by row and
// column parity, clamp, scale, weight and blend pipeline; depends on bts_pkg, bts_bank
`default_nettype none
// One item is taken in every cycle. A sample item gives its result on
// red_out, green_out and blue_out with strobe high; a load gives no result.
// The four texels of a 2x2 neighborhood lie in four banks (row and column
// parity), so each bank serves one read per cycle. A load passes through
// ld_v1 and ld_v2 and is written at the edge where a sample taken in its
// place would read, so every sample sees exactly the loads taken before it.
// The receiver cannot stall; busy is always low.
module bilinear_texture_sampler (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [8:0]  cfg_data,
  input  wire         mode,
  input  wire  signed [17:0] u_coord,
  input  wire  signed [17:0] v_coord,
  input  wire  [7:0]  texel_col,
  input  wire  [7:0]  texel_row,
  input  wire  [15:0] red_in,
  input  wire  [15:0] green_in,
  input  wire  [15:0] blue_in,
  output logic        strobe,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out
);
  logic [8:0] image_width;
  logic [8:0] image_height;
  logic [8:0] cfg_sat;

  always_comb begin
    if (cfg_data < 9'd2) begin
      cfg_sat = 9'd2;
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bts_pkg::MaxCols;
      image_height <= bts_pkg::MaxRows;
    end else if (cfg_we) begin
      case (bts_pkg::reg_idx_t'(cfg_index))
        bts_pkg::REG_WIDTH:  image_width <= (cfg_sat > bts_pkg::MaxCols) ?
                                            bts_pkg::MaxCols : cfg_sat;
        bts_pkg::REG_HEIGHT: image_height <= (cfg_sat > bts_pkg::MaxRows) ?
                                             bts_pkg::MaxRows : cfg_sat;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: clamp
  logic [16:0] uc;
  logic [16:0] vc;
  logic [16:0] u1;
  logic [16:0] v1;

  always_comb begin
    if (u_coord[17]) begin
      uc = '0;
    end else if (u_coord[16:0] > bts_pkg::OneQ16) begin
      uc = bts_pkg::OneQ16;
    end else begin
      uc = u_coord[16:0];
    end
    if (v_coord[17]) begin
      vc = '0;
    end else if (v_coord[16:0] > bts_pkg::OneQ16) begin
      vc = bts_pkg::OneQ16;
    end else begin
      vc = v_coord[16:0];
    end
  end

  // stage 1: scale
  logic [24:0] xs;
  logic [24:0] ys;
  logic [8:0]  wm1;
  logic [8:0]  hm1;
  assign wm1 = image_width - 9'd1;
  assign hm1 = image_height - 9'd1;

  always_ff @(posedge clk) begin
    u1 <= uc;
    v1 <= vc;
    xs <= 25'(u1) * 25'(wm1);
    ys <= 25'(v1) * 25'(hm1);
  end

  // stage 2: locate and address the banks
  logic [8:0]  xi;
  logic [8:0]  yi;
  logic [16:0] xf;
  logic [16:0] yf;
  logic [7:0]  jj;
  logic [7:0]  ii;

  always_comb begin
    xi = xs[24:16];
    yi = ys[24:16];
    if (xi >= wm1) begin
      jj = 8'(image_width - 9'd2);
      xf = bts_pkg::OneQ16;
    end else begin
      jj = xi[7:0];
      xf = {1'b0, xs[15:0]};
    end
    if (yi >= hm1) begin
      ii = 8'(image_height - 9'd2);
      yf = bts_pkg::OneQ16;
    end else begin
      ii = yi[7:0];
      yf = {1'b0, ys[15:0]};
    end
  end

  logic [7:0] j1;
  logic [7:0] i1;
  logic [6:0] ce;
  logic [6:0] co;
  logic [6:0] re;
  logic [6:0] ro;
  assign j1 = jj + 8'd1;
  assign i1 = ii + 8'd1;
  assign ce = jj[0] ? j1[7:1] : jj[7:1];
  assign co = jj[0] ? jj[7:1] : j1[7:1];
  assign re = ii[0] ? i1[7:1] : ii[7:1];
  assign ro = ii[0] ? ii[7:1] : i1[7:1];

  // loads trail through the ld_v1 and ld_v2 registers to line up with the sample reads
  logic            ld_v1;
  logic            ld_v2;
  logic [7:0]      ld_col1;
  logic [7:0]      ld_col2;
  logic [7:0]      ld_row1;
  logic [7:0]      ld_row2;
  bts_pkg::texel_t ld_d1;
  bts_pkg::texel_t ld_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v1 <= 1'b0;
      ld_v2 <= 1'b0;
    end else begin
      ld_v1 <= start && !mode;
      ld_v2 <= ld_v1;
    end
    ld_col1 <= texel_col;
    ld_col2 <= ld_col1;
    ld_row1 <= texel_row;
    ld_row2 <= ld_row1;
    ld_d1 <= {blue_in, green_in, red_in};
    ld_d2 <= ld_d1;
  end

  bts_pkg::texel_t rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [bts_pkg::BankAw-1:0] ra;
    assign ra = {(b[1] ? ro : re), (b[0] ? co : ce)};
    bts_bank u_bank (
      .clk   (clk),
      .we    (ld_v2 && ld_row2[0] == b[1] && ld_col2[0] == b[0]),
      .waddr ({ld_row2[7:1], ld_col2[7:1]}),
      .wdata (ld_d2),
      .raddr (ra),
      .rdata (rd[b])
    );
  end

  // stage 3: bank data ready; stage 2 regs
  logic [16:0] xf3;
  logic [16:0] yf3;
  logic        jo3;
  logic        io3;
  always_ff @(posedge clk) begin
    xf3 <= xf;
    yf3 <= yf;
    jo3 <= jj[0];
    io3 <= ii[0];
  end

  bts_pkg::texel_t t00;
  bts_pkg::texel_t t01;
  bts_pkg::texel_t t10;
  bts_pkg::texel_t t11;
  always_comb begin
    t00 = rd[{io3, jo3}];
    t01 = rd[{io3, ~jo3}];
    t10 = rd[{~io3, jo3}];
    t11 = rd[{~io3, ~jo3}];
  end

  // stage 4: weights (17x17 products)
  logic [33:0] w00;
  logic [33:0] w01;
  logic [33:0] w10;
  logic [33:0] w11;
  bts_pkg::texel_t s00;
  bts_pkg::texel_t s01;
  bts_pkg::texel_t s10;
  bts_pkg::texel_t s11;
  logic [16:0] ax;
  logic [16:0] by;
  assign ax = bts_pkg::OneQ16 - xf3;
  assign by = bts_pkg::OneQ16 - yf3;

  always_ff @(posedge clk) begin
    w00 <= 34'(ax) * 34'(by);
    w10 <= 34'(ax) * 34'(yf3);
    w01 <= 34'(xf3) * 34'(by);
    w11 <= 34'(xf3) * 34'(yf3);
    s00 <= t00;
    s01 <= t01;
    s10 <= t10;
    s11 <= t11;
  end

  // stage 5: weight times channel, one multiply per tap and channel
  // weights are at most 2^32; split as high bit plus 32-bit part
  logic [48:0] p [3][4];
  for (genvar k = 0; k < 3; k++) begin : g_ch
    logic [15:0] c00;
    logic [15:0] c01;
    logic [15:0] c10;
    logic [15:0] c11;
    assign c00 = s00[k*16 +: 16];
    assign c01 = s01[k*16 +: 16];
    assign c10 = s10[k*16 +: 16];
    assign c11 = s11[k*16 +: 16];
    always_ff @(posedge clk) begin
      p[k][0] <= w00[32] ? {1'b0, c00, 32'd0} : 49'(w00[31:0]) * 49'(c00);
      p[k][1] <= w10[32] ? {1'b0, c10, 32'd0} : 49'(w10[31:0]) * 49'(c10);
      p[k][2] <= w01[32] ? {1'b0, c01, 32'd0} : 49'(w01[31:0]) * 49'(c01);
      p[k][3] <= w11[32] ? {1'b0, c11, 32'd0} : 49'(w11[31:0]) * 49'(c11);
    end
  end

  // stage 6: sum and round
  logic [50:0] acc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 51'(p[k][0]) + 51'(p[k][1]) + 51'(p[k][2]) + 51'(p[k][3])
               + 51'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    red_out <= acc[0][47:32];
    green_out <= acc[1][47:32];
    blue_out <= acc[2][47:32];
  end

  // valid pipe: entry, scale, locate and bank read, weights, products, output
  logic [5:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[4:0], start && mode};
    end
  end
  assign strobe = vpipe[5];
endmodule
`default_nettype wire

FILE: hw/rtl/bts_bank.sv
// bts_bank: one bank of the texel store, one write and one read port
// depends on bts_pkg
`default_nettype none
module bts_bank (
  input  wire                        clk,
  input  wire                        we,
  input  wire [bts_pkg::BankAw-1:0]  waddr,
  input  wire bts_pkg::texel_t       wdata,
  input  wire [bts_pkg::BankAw-1:0]  raddr,
  output bts_pkg::texel_t            rdata
);
  bts_pkg::texel_t mem [0:(1 << bts_pkg::BankAw)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
